/* src/mtwp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwp_pkg: shared types and constants of the write-frame parser
// Frame geometry, function codes, reply constants and the job record that
// travels from the parsing front end to the result back end.
// ----------------------------------------------------------------------------
package mtwp_pkg;

  localparam int unsigned HdrLen    = 12;
  localparam int unsigned PosW      = 17;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW      = 4;

  localparam logic [PosW-1:0] PosLenHi      = PosW'(5);
  localparam logic [PosW-1:0] PosHdrLast    = PosW'(11);
  localparam logic [PosW-1:0] PosFirstValue = PosW'(13);
  localparam logic [PosW-1:0] MinFrameLen   = PosW'(HdrLen);
  localparam logic [PosW-1:0] MbapPrefix    = PosW'(6);

  localparam logic [7:0] FuncWrSingle = 8'd6;
  localparam logic [7:0] FuncWrMulti  = 8'd16;
  localparam logic [7:0] ExcFunc      = 8'd134;
  localparam logic [7:0] ExcLen       = 8'd3;
  localparam logic [7:0] ExcCode      = 8'd1;

  localparam logic [IdxW-1:0] EchoReplyLen = IdxW'(12);
  localparam logic [IdxW-1:0] ExcReplyLen  = IdxW'(9);

  // Positions within the exception reply
  localparam logic [IdxW-1:0] ExcPosLenHi = IdxW'(4);
  localparam logic [IdxW-1:0] ExcPosLenLo = IdxW'(5);
  localparam logic [IdxW-1:0] ExcPosUnit  = IdxW'(6);
  localparam logic [IdxW-1:0] ExcPosFunc  = IdxW'(7);
  localparam logic [IdxW-1:0] ExcPosCode  = IdxW'(8);

  typedef enum logic [1:0] {
    REP_NONE,
    REP_ECHO,
    REP_EXC
  } reply_e;

  typedef logic [HdrLen-1:0][7:0] hdr_t;

  typedef struct packed {
    logic        has_wr;
    logic [7:0]  station;
    logic [15:0] addr;
    logic [15:0] value;
    reply_e      reply;
    hdr_t        hdr;
  } job_t;

endpackage

/* src/mtwp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwp_front: frame tracker and request classifier
// Follows the position in the frame, keeps the header bytes and the register
// counters, and turns each received byte into at most one job.
// ----------------------------------------------------------------------------
module mtwp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rx_valid_i,
  output logic           rx_ready_o,
  input  logic [7:0]     rx_byte_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output mtwp_pkg::job_t job_o
);
  import mtwp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] len_q, len_d;
  logic [15:0]     vrem_q, vrem_d;
  logic [15:0]     nreg_q, nreg_d;
  logic [7:0]      vhi_q, vhi_d;
  hdr_t            hdr_q, hdr_eff;

  logic            accept;
  logic [7:0]      func;
  logic [PosW-1:0] new_len;
  logic            load_multi;
  logic            in_values;
  logic            val_wr;
  logic            frame_end;

  assign rx_ready_o = job_ready_i;
  assign accept     = rx_valid_i && rx_ready_o;

  always_comb begin
    hdr_eff = hdr_q;
    if (pos_q < MinFrameLen) begin
      hdr_eff[pos_q[IdxW-1:0]] = rx_byte_i;
    end
  end

  assign func    = hdr_eff[7];
  assign new_len = MbapPrefix + PosW'({hdr_eff[4], hdr_eff[5]});

  assign load_multi = (pos_q == PosHdrLast) && (func == FuncWrMulti);
  assign in_values  = (func == FuncWrMulti) && (pos_q >= PosFirstValue) && (pos_q < len_q);
  // Values start on an odd position: odd is a high byte, even a low byte
  assign val_wr     = in_values && !pos_q[0] && (vrem_q != 16'd0);
  assign frame_end  = (pos_q >= PosHdrLast) &&
                      ({1'b0, pos_q} + (PosW+1)'(1) >= {1'b0, len_q});

  always_comb begin
    job_o.has_wr  = val_wr || (frame_end && (func == FuncWrSingle));
    job_o.station = hdr_eff[6];
    job_o.addr    = val_wr ? nreg_q : {hdr_eff[8], hdr_eff[9]};
    job_o.value   = val_wr ? {vhi_q, rx_byte_i} : {hdr_eff[10], hdr_eff[11]};
    job_o.hdr     = hdr_eff;
    if (!frame_end) begin
      job_o.reply = REP_NONE;
    end else if ((func == FuncWrSingle) || (func == FuncWrMulti)) begin
      job_o.reply = REP_ECHO;
    end else begin
      job_o.reply = REP_EXC;
    end
  end

  assign job_valid_o = accept && (job_o.has_wr || frame_end);

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    vrem_d = vrem_q;
    nreg_d = nreg_q;
    vhi_d  = vhi_q;
    if (accept) begin
      if (pos_q == PosLenHi) begin
        len_d = (new_len < MinFrameLen) ? MinFrameLen : new_len;
      end
      if (load_multi) begin
        nreg_d = {hdr_eff[8], hdr_eff[9]};
        vrem_d = {hdr_eff[10], hdr_eff[11]};
      end
      if (in_values && pos_q[0]) begin
        vhi_d = rx_byte_i;
      end
      if (val_wr) begin
        nreg_d = nreg_q + 16'd1;
        vrem_d = vrem_q - 16'd1;
      end
      if (frame_end) begin
        pos_d  = '0;
        len_d  = '0;
        vrem_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      vrem_q <= '0;
      nreg_q <= '0;
      vhi_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      vrem_q <= vrem_d;
      nreg_q <= nreg_d;
      vhi_q  <= vhi_d;
    end
  end

  // Header store: undefined until written, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q <= hdr_eff;
    end
  end

endmodule

/* src/mtwp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwp_queue: job queue
// Small FIFO between the front end and the back end so each side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module mtwp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  mtwp_pkg::job_t push_job_i,
  output logic           head_valid_o,
  input  logic           pop_i,
  output mtwp_pkg::job_t head_job_o
);
  import mtwp_pkg::*;

  job_t             entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

/* src/mtwp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwp_back: result sequencer
// Expands the job at the head of the queue into its register write, if any, and reply
// bytes, one result per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module mtwp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  mtwp_pkg::job_t head_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           kind_o,
  output logic [7:0]     station_o,
  output logic [15:0]    reg_address_o,
  output logic [15:0]    reg_value_o,
  output logic [7:0]     tx_byte_o,
  output logic           last_o
);
  import mtwp_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            ovalid_q, ovalid_d;
  logic            kind_q, last_q;
  logic [7:0]      station_q, tx_q;
  logic [15:0]     addr_q, value_q;

  logic [IdxW-1:0] reply_len, total, k;
  logic            advance, is_wr, is_last;
  logic [7:0]      rep_byte;

  always_comb begin
    unique case (head_job_i.reply)
      REP_NONE: reply_len = '0;
      REP_ECHO: reply_len = EchoReplyLen;
      REP_EXC:  reply_len = ExcReplyLen;
      default:  reply_len = '0;
    endcase
  end

  assign total   = reply_len + IdxW'(head_job_i.has_wr);
  assign is_wr   = head_job_i.has_wr && (idx_q == '0);
  assign k       = idx_q - IdxW'(head_job_i.has_wr);
  assign is_last = (idx_q == total - IdxW'(1));
  assign advance = head_valid_i && (!ovalid_q || out_ready_i);
  assign pop_o   = advance && is_last;

  always_comb begin
    rep_byte = head_job_i.hdr[k];
    if (head_job_i.reply == REP_EXC) begin
      priority if (k == ExcPosLenHi) begin
        rep_byte = 8'd0;
      end else if (k == ExcPosLenLo) begin
        rep_byte = ExcLen;
      end else if (k == ExcPosUnit) begin
        rep_byte = head_job_i.hdr[6];
      end else if (k == ExcPosFunc) begin
        rep_byte = ExcFunc;
      end else if (k == ExcPosCode) begin
        rep_byte = ExcCode;
      end else begin
        rep_byte = head_job_i.hdr[k];
      end
    end
  end

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (advance) begin
      ovalid_d = 1'b1;
      idx_d    = is_last ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q    <= !is_wr;
      station_q <= is_wr ? head_job_i.station : 8'd0;
      addr_q    <= is_wr ? head_job_i.addr : 16'd0;
      value_q   <= is_wr ? head_job_i.value : 16'd0;
      tx_q      <= is_wr ? 8'd0 : rep_byte;
      last_q    <= is_last;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign kind_o        = kind_q;
  assign station_o     = station_q;
  assign reg_address_o = addr_q;
  assign reg_value_o   = value_q;
  assign tx_byte_o     = tx_q;
  assign last_o        = last_q;

endmodule

/* src/modbus_tcp_write_frame_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_tcp_write_frame_parser_unit: Modbus TCP write-register request parser
// Splits a received byte stream into frames, emits register writes for
// functions 6 and 16 and queues the echo or exception reply bytes.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------------
//  rx       | rx_valid_i / rx_ready_o | rx_byte_i
//  result   | out_valid_o/out_ready_i | kind_o station_o reg_address_o
//           |                        | reg_value_o tx_byte_o last_o
//
//  One received byte is taken per cycle while the job queue has room.
//  Results leave one per cycle, while out_ready_i is high, from a registered
//  output stage; a byte that closes a frame yields up to 13 results, set by the
//  single result sequencer, and each job passes the queue, then that stage.
//  Reset clears the frame tracker, the queue and the output stage.
//  A stalled output fills the four-entry queue, which then drops rx_ready_o.
// ----------------------------------------------------------------------------
module modbus_tcp_write_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  station_o,
  output logic [15:0] reg_address_o,
  output logic [15:0] reg_value_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o
);
  import mtwp_pkg::*;

  job_t push_job, head_job;
  logic push, push_ready, head_valid, pop;

  mtwp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .job_valid_o (push),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  mtwp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_job_o   (head_job)
  );

  mtwp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_job_i    (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .station_o     (station_o),
    .reg_address_o (reg_address_o),
    .reg_value_o   (reg_value_o),
    .tx_byte_o     (tx_byte_o),
    .last_o        (last_o)
  );

endmodule

/* test/modbus_tcp_write_frame_parser_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_tcp_write_frame_parser_unit_tb: self-checking bench for the parser
// Streams Modbus TCP request frames into the block, one byte per request, and
// checks every register write and reply byte against a frame tracker kept in
// the bench. A short table of hand-built frames runs first, then random
// frames, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module modbus_tcp_write_frame_parser_unit_tb;
  import mtwp_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 9;
  localparam int StreamLen   = 470;
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 80;
  localparam int TimeoutNs   = 2_000_000;
  localparam int NoTableTx   = -1;

  typedef enum logic {
    RES_WRITE = 1'b0,
    RES_REPLY = 1'b1
  } res_kind_e;

  typedef struct {
    res_kind_e   kind;
    logic [7:0]  station;
    logic [15:0] addr;
    logic [15:0] value;
    logic [7:0]  tx;
    logic        last;
    int          table_tx;
  } result_t;

  typedef struct packed {
    logic [7:0] b;
    int         last_tx;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        rx_valid_i  = 1'b0;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [7:0]  station_o;
  logic [15:0] reg_address_o;
  logic [15:0] reg_value_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;

  // typed-in final reply byte of the request in flight, if any
  int rx_table_tx = NoTableTx;

  // frame tracker state
  logic [7:0]      hdr_seen [HdrLen];
  logic [PosW-1:0] frame_pos;
  logic [PosW-1:0] frame_len;
  logic [15:0]     vals_left;
  logic [15:0]     next_reg;
  logic [7:0]      val_hi;

  result_t due_results [$];

  int  mismatches    = 0;
  int  n_sent        = 0;
  int  frames_closed = 0;
  int  writes_seen   = 0;
  int  replies_seen  = 0;
  bit  calm          = 1'b0;
  bit  held_off      = 1'b0;

  // Three hand-built frames: unknown function with a short length field,
  // function 6 with a trailing byte, function 16 with address wrap and a
  // dangling high byte. Closing rows carry the last reply byte.
  dir_row_t dir_table [43] = '{
    '{8'hFF, NoTableTx}, '{8'hFF, NoTableTx}, '{8'h00, NoTableTx}, '{8'h00, NoTableTx},
    '{8'h00, NoTableTx}, '{8'h00, NoTableTx}, '{8'hFF, NoTableTx}, '{8'hFF, NoTableTx},
    '{8'h00, NoTableTx}, '{8'h00, NoTableTx}, '{8'h00, NoTableTx},
    '{8'h00, int'(ExcCode)},
    '{8'h00, NoTableTx}, '{8'h01, NoTableTx}, '{8'h00, NoTableTx}, '{8'h00, NoTableTx},
    '{8'h00, NoTableTx}, '{8'h07, NoTableTx}, '{8'h11, NoTableTx}, '{8'h06, NoTableTx},
    '{8'hFF, NoTableTx}, '{8'hFF, NoTableTx}, '{8'hFF, NoTableTx}, '{8'hFF, NoTableTx},
    '{8'h5A, 8'hFF},
    '{8'h00, NoTableTx}, '{8'h02, NoTableTx}, '{8'h00, NoTableTx}, '{8'h00, NoTableTx},
    '{8'h00, NoTableTx}, '{8'h0C, NoTableTx}, '{8'h00, NoTableTx}, '{8'h10, NoTableTx},
    '{8'hFF, NoTableTx}, '{8'hFF, NoTableTx}, '{8'h00, NoTableTx}, '{8'h02, NoTableTx},
    '{8'h06, NoTableTx}, '{8'h12, NoTableTx}, '{8'h34, NoTableTx}, '{8'hAB, NoTableTx},
    '{8'hCD, NoTableTx},
    '{8'hEE, 8'h02}
  };

  modbus_tcp_write_frame_parser_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .station_o    (station_o),
    .reg_address_o(reg_address_o),
    .reg_value_o  (reg_value_o),
    .tx_byte_o    (tx_byte_o),
    .last_o       (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void add_result(input res_kind_e k, input logic [7:0] st,
                                     input logic [15:0] a, input logic [15:0] v,
                                     input logic [7:0] tx);
    due_results.push_back('{k, st, a, v, tx, 1'b0, NoTableTx});
  endfunction

  // Advance the frame tracker by one received byte and queue what it causes.
  function automatic void parse_stream_byte(input logic [7:0] b, input int table_tx);
    logic [PosW-1:0] p;
    logic [PosW-1:0] len;
    logic [7:0]      fn;
    int              before_n;
    p = frame_pos;
    before_n = due_results.size();
    if (p < HdrLen) hdr_seen[p] = b;
    if (p == PosLenHi) begin
      len = MbapPrefix + PosW'({hdr_seen[4], hdr_seen[5]});
      frame_len = (len < MinFrameLen) ? MinFrameLen : len;
    end
    fn = hdr_seen[7];
    if (p == PosHdrLast && fn == FuncWrMulti) begin
      next_reg  = {hdr_seen[8], hdr_seen[9]};
      vals_left = {hdr_seen[10], hdr_seen[11]};
    end
    // values start at an odd position: odd is the high byte, even the low
    if (fn == FuncWrMulti && p >= PosFirstValue && p < frame_len) begin
      if (p[0]) begin
        val_hi = b;
      end else if (vals_left != 0) begin
        add_result(RES_WRITE, hdr_seen[6], next_reg, {val_hi, b}, 8'h00);
        next_reg++;
        vals_left--;
      end
    end
    if (p >= PosHdrLast && p + 1 >= frame_len) begin
      if (fn == FuncWrSingle)
        add_result(RES_WRITE, hdr_seen[6], {hdr_seen[8], hdr_seen[9]},
                   {hdr_seen[10], hdr_seen[11]}, 8'h00);
      if (fn == FuncWrSingle || fn == FuncWrMulti) begin
        for (int i = 0; i < HdrLen; i++) add_result(RES_REPLY, '0, '0, '0, hdr_seen[i]);
      end else begin
        for (int i = 0; i < 4; i++) add_result(RES_REPLY, '0, '0, '0, hdr_seen[i]);
        add_result(RES_REPLY, '0, '0, '0, 8'h00);
        add_result(RES_REPLY, '0, '0, '0, ExcLen);
        add_result(RES_REPLY, '0, '0, '0, hdr_seen[6]);
        add_result(RES_REPLY, '0, '0, '0, ExcFunc);
        add_result(RES_REPLY, '0, '0, '0, ExcCode);
      end
      frame_pos = '0;
      frame_len = '0;
      vals_left = '0;
      frames_closed++;
    end else begin
      frame_pos = p + PosW'(1);
    end
    if (due_results.size() > before_n) begin
      due_results[$].last     = 1'b1;
      due_results[$].table_tx = table_tx;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with nothing due: kind %0d tx 0x%0h addr 0x%0h",
                 kind_o, tx_byte_o, reg_address_o);
          mismatches++;
        end else begin
          e = due_results.pop_front();
          check_field("kind", e.kind, kind_o);
          check_field("station", e.station, station_o);
          check_field("reg_address", e.addr, reg_address_o);
          check_field("reg_value", e.value, reg_value_o);
          check_field("tx_byte", e.tx, tx_byte_o);
          check_field("last", e.last, last_o);
          if (e.table_tx != NoTableTx)
            check_field("tx_byte (table)", e.table_tx[7:0], tx_byte_o);
          if (e.kind == RES_WRITE) writes_seen++;
          else replies_seen++;
        end
      end
      if (rx_valid_i && rx_ready_o) parse_stream_byte(rx_byte_i, rx_table_tx);
    end
  end

  // Offer one byte, idling at random first; return on the falling edge after
  // the request is taken.
  task automatic send_byte(input logic [7:0] b, input int table_tx);
    while (!calm && $urandom_range(99) < 14) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    rx_table_tx <= table_tx;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    n_sent++;
    calm = (n_sent >= 250 && n_sent < 330);
    @(negedge clk_i);
  endtask

  task automatic send_random_frame();
    logic [7:0]  fr [$];
    logic [7:0]  fn;
    logic [15:0] addr;
    logic [15:0] word;
    logic [15:0] lenf;
    int          sel;
    int          nvals;
    int          total;
    sel   = $urandom_range(99);
    addr  = ($urandom_range(4) == 0) ? 16'hFFFF - 16'($urandom_range(2)) : 16'($urandom);
    word  = 16'($urandom);
    total = 12;
    if (sel < 40) begin
      fn    = FuncWrMulti;
      nvals = ($urandom_range(19) == 0) ? 8 : $urandom_range(4);
      total = 13 + 2 * nvals + (($urandom_range(3) == 0) ? 1 : 0);
      // mostly a matching register count; otherwise a random one from 0 to 6
      word  = ($urandom_range(4) < 3) ? 16'(nvals) : 16'($urandom_range(6));
    end else if (sel < 70) begin
      fn    = FuncWrSingle;
      total = ($urandom_range(3) == 0) ? 12 + $urandom_range(4, 1) : 12;
    end else if (sel < 85) begin
      fn = 8'($urandom);
      while (fn == FuncWrSingle || fn == FuncWrMulti) fn = 8'($urandom);
      total = $urandom_range(16, 12);
    end else begin
      case ($urandom_range(2))
        0:       fn = FuncWrSingle;
        1:       fn = FuncWrMulti;
        default: fn = 8'($urandom);
      endcase
    end
    lenf = (sel >= 85) ? 16'($urandom_range(5)) : 16'(total - 6);
    fr.push_back(8'($urandom));
    fr.push_back(8'($urandom));
    fr.push_back(($urandom_range(4) == 0) ? 8'($urandom) : 8'h00);
    fr.push_back(($urandom_range(4) == 0) ? 8'($urandom) : 8'h00);
    fr.push_back(lenf[15:8]);
    fr.push_back(lenf[7:0]);
    fr.push_back(8'($urandom));
    fr.push_back(fn);
    fr.push_back(addr[15:8]);
    fr.push_back(addr[7:0]);
    fr.push_back(word[15:8]);
    fr.push_back(word[7:0]);
    while (fr.size() < total) fr.push_back(8'($urandom));
    foreach (fr[i]) send_byte(fr[i], NoTableTx);
  endtask

  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // one long stall while requests keep coming, to back the block up
      if (!held_off && n_sent >= 120) begin
        held_off = 1'b1;
        hold     = 0;
        while (hold < HoldCycles) begin
          out_ready_i <= 1'b0;
          @(negedge clk_i);
          hold++;
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 14);
    end
  end

  initial begin : stimulus
    foreach (hdr_seen[i]) hdr_seen[i] = '0;
    frame_pos = '0;
    frame_len = '0;
    vals_left = '0;
    next_reg  = '0;
    val_hi    = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_table[i]) send_byte(dir_table[i].b, dir_table[i].last_tx);
    while (n_sent < StreamLen) send_random_frame();
    rx_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Streamed %0d bytes in %0d frames; checked %0d register writes and %0d reply bytes",
             n_sent, frames_closed, writes_seen, replies_seen);
    $display("Output stall hold-off done: %0d, mismatches: %0d", held_off, mismatches);
    if (mismatches == 0) begin
      $display("modbus_tcp_write_frame_parser_unit verification clean");
    end else begin
      $display("modbus_tcp_write_frame_parser_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Timed out with %0d results still due", due_results.size());
    $display("modbus_tcp_write_frame_parser_unit verification failed");
    $finish;
  end

endmodule

/* filelist.f */
src/mtwp_pkg.sv
src/mtwp_front.sv
src/mtwp_queue.sv
src/mtwp_back.sv
src/modbus_tcp_write_frame_parser_unit.sv
test/modbus_tcp_write_frame_parser_unit_tb.sv
